// ===== sv/scfi_pkg.sv =====
// Shared constants, types and the sine table for the sine/cosine block.
package scfi_pkg;

  // Angles in degrees with 6 fraction bits.
  localparam int unsigned AngleW = 16;
  localparam int unsigned RedW   = 18;   // signed width for range reduction
  localparam int unsigned QW     = 13;   // first-quadrant angle, 0..5760
  localparam int unsigned IdxW   = 5;    // table index
  localparam int unsigned LutW   = 15;   // table entries are non-negative Q14
  localparam int unsigned DiffW  = 11;   // largest step between entries is 1142
  localparam int unsigned ValW   = 16;

  localparam logic signed [RedW-1:0] DEG90      = 18'sd5760;
  localparam logic signed [RedW-1:0] DEG180     = 18'sd11520;
  localparam logic signed [RedW-1:0] DEG270     = 18'sd17280;
  localparam logic signed [RedW-1:0] DEG360     = 18'sd23040;
  localparam logic signed [RedW-1:0] DEG720     = 18'sd46080;
  localparam logic [AngleW-1:0]      COS_OFFSET = 16'd5760;
  localparam logic [AngleW-1:0]      FRAC_MASK  = 16'hFF00;
  localparam logic [IdxW-1:0]        IDX_LAST   = 5'd22;
  localparam logic signed [ValW-1:0] VAL_MAX    = 16'sd16394;

  // Selector codes carried in tuser.
  localparam logic ACT_SINE   = 1'b0;
  localparam logic ACT_COSINE = 1'b1;

  // Result of range reduction and quadrant fold.
  typedef struct packed {
    logic [QW-1:0] q;     // angle folded into 0..90 degrees
    logic          neg;   // lower half of the circle
  } fold_t;

  // sin(4k degrees) in Q14, truncated; last entry trimmed so 90 degrees is exact.
  function automatic logic [LutW-1:0] sine_lut(input logic [IdxW-1:0] idx);
    logic [LutW-1:0] r;
    case (idx)
      5'd0:    r = 15'd0;
      5'd1:    r = 15'd1142;
      5'd2:    r = 15'd2280;
      5'd3:    r = 15'd3406;
      5'd4:    r = 15'd4516;
      5'd5:    r = 15'd5603;
      5'd6:    r = 15'd6663;
      5'd7:    r = 15'd7691;
      5'd8:    r = 15'd8682;
      5'd9:    r = 15'd9630;
      5'd10:   r = 15'd10531;
      5'd11:   r = 15'd11381;
      5'd12:   r = 15'd12175;
      5'd13:   r = 15'd12910;
      5'd14:   r = 15'd13582;
      5'd15:   r = 15'd14188;
      5'd16:   r = 15'd14725;
      5'd17:   r = 15'd15190;
      5'd18:   r = 15'd15582;
      5'd19:   r = 15'd15897;
      5'd20:   r = 15'd16135;
      5'd21:   r = 15'd16294;
      5'd22:   r = 15'd16374;
      5'd23:   r = 15'd16394;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/scfi_fold.sv =====
// Cosine offset, range reduction into 0..360 degrees and fold into the first quadrant.
module scfi_fold (
  input  logic                           action,
  input  logic [scfi_pkg::AngleW-1:0]    angle,
  output scfi_pkg::fold_t                fold
);
  import scfi_pkg::*;

  logic [AngleW-1:0]      raw;
  logic signed [RedW-1:0] v;
  logic signed [RedW-1:0] r;
  logic signed [RedW-1:0] q_wide;

  // Cosine is sine shifted by 90 degrees; the sum wraps in 16 bits.
  assign raw = (action == ACT_COSINE) ? angle + COS_OFFSET : angle;
  assign v   = RedW'($signed(raw));

  // Bring the angle into 0..360; exactly 360 is kept as is.
  always_comb begin
    if (v > DEG360) begin
      r = v - DEG360;
    end else if (v < -DEG360) begin
      r = v + DEG720;
    end else if (v < 0) begin
      r = v + DEG360;
    end else begin
      r = v;
    end
  end

  // Fold by quadrant; boundary angles belong to the lower quadrant.
  always_comb begin
    if (r > DEG270) begin
      q_wide   = DEG360 - r;
      fold.neg = 1'b1;
    end else if (r > DEG180) begin
      q_wide   = r - DEG180;
      fold.neg = 1'b1;
    end else if (r > DEG90) begin
      q_wide   = DEG180 - r;
      fold.neg = 1'b0;
    end else begin
      q_wide   = r;
      fold.neg = 1'b0;
    end
    fold.q = q_wide[QW-1:0];
  end

endmodule

// ===== sv/scfi_interp.sv =====
// Table lookup with linear interpolation and sign for the folded angle.
module scfi_interp (
  input  scfi_pkg::fold_t              fold,
  output logic [scfi_pkg::ValW-1:0]    value
);
  import scfi_pkg::*;

  logic [IdxW-1:0]       idx;
  logic [7:0]            frac;
  logic [LutW-1:0]       left;
  logic [LutW-1:0]       right;
  logic [DiffW-1:0]      diff;
  logic [DiffW+7:0]      prod;
  logic [LutW-1:0]       mag;

  // Interval index and the 8-bit position within it.
  assign idx  = (fold.q[QW-1:8] > IDX_LAST) ? IDX_LAST : fold.q[QW-1:8];
  assign frac = fold.q[7:0] & ~FRAC_MASK[7:0];

  // Table is increasing, so the step and the product are non-negative.
  assign left  = sine_lut(idx);
  assign right = sine_lut(idx + IdxW'(1));
  assign diff  = DiffW'(right - left);
  assign prod  = frac * diff;
  assign mag   = left + LutW'(prod[DiffW+7:8]);

  // Lower half of the circle negates.
  assign value = fold.neg ? ValW'(-{1'b0, mag}) : ValW'({1'b0, mag});

endmodule

// ===== sv/sine_cosine_fp6_interp.sv =====
// Top level of the sine/cosine block: input register, compute logic, result register.
// Sine or cosine of an angle in degrees (signed, 6 fraction bits), returned in signed
// Q14. The block takes one item per clock unless a stalled output holds it back. An
// accepted item enters the input register, then a single pass of range reduction,
// quadrant fold, two table reads and an 8-bit interpolation multiply feeds the result
// register. Both registers advance together whenever the result is taken or empty,
// so a stalled output holds back input only when both are full.
// tuser carries the selector (0 = sine, 1 = cosine); any 16-bit angle gives a result.
module sine_cosine_fp6_interp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [scfi_pkg::AngleW-1:0]     s_axis_tdata,   // [15:0] angle
  input  logic                            s_axis_tuser,   // [0] action
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [scfi_pkg::ValW-1:0]       m_axis_tdata    // [15:0] value
);
  import scfi_pkg::*;

  logic              s1_valid;
  logic              s1_action;
  logic [AngleW-1:0] s1_angle;
  logic              out_advance;
  fold_t             fold;
  logic [ValW-1:0]   value;

  // Result register takes a new value when it is empty or being read.
  assign out_advance   = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || out_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_action <= s_axis_tuser;
      s1_angle  <= s_axis_tdata;
    end
  end

  scfi_fold u_fold (
    .action (s1_action),
    .angle  (s1_angle),
    .fold   (fold)
  );

  scfi_interp u_interp (
    .fold  (fold),
    .value (value)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_advance) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && s1_valid) begin
      m_axis_tdata <= value;
    end
  end

  // A shown result always lies within the table's range.
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata) <= VAL_MAX &&
                       $signed(m_axis_tdata) >= -VAL_MAX))
    else $error("result outside Q14 range");

  // The folded angle never exceeds 90 degrees.
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (fold.q <= QW'(DEG90)))
    else $error("folded angle above 90 degrees");

  // Input is held off only when both registers are full and the output stalls.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without cause");

  // An accepted item reaches the input register.
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> s1_valid)
    else $error("accepted item lost");

  // A waiting item moves on to the result register when it is free.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_advance) |=> m_axis_tvalid)
    else $error("item not moved to result register");

endmodule
